[design/vurf_pkg.sv]
// Shared types and constants for the video unit register file.
package vurf_pkg;

  localparam int REG_WINDOW = 8;
  localparam int SEL_W      = $clog2(REG_WINDOW);

  localparam logic [13:0] NT_BASE      = 14'h2000;
  localparam logic [13:0] NT_STEP      = 14'h0400;
  localparam logic [12:0] PATTERN_HI   = 13'h1000;
  localparam logic [5:0]  INC_NARROW   = 6'd1;
  localparam logic [5:0]  INC_WIDE     = 6'd32;
  localparam logic [2:0]  STATUS_RESET = 3'b101;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_EVENT = 2'd2
  } req_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_CONTROL   = 3'd0,
    SEL_MASK      = 3'd1,
    SEL_STATUS    = 3'd2,
    SEL_OAM_ADDR  = 3'd3,
    SEL_OAM_DATA  = 3'd4,
    SEL_SCROLL    = 3'd5,
    SEL_VRAM_ADDR = 3'd6,
    SEL_VRAM_DATA = 3'd7
  } sel_t;

  typedef enum logic [1:0] {
    FLAG_OVERFLOW = 2'd0,
    FLAG_HIT      = 2'd1,
    FLAG_VBLANK   = 2'd2
  } flag_t;

  typedef struct packed {
    logic [7:0]  control;
    logic [7:0]  mask;
    logic [2:0]  status;
    logic [7:0]  spr_ptr;
    logic [7:0]  spr_byte;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
    logic [15:0] vid_ptr;
    logic        toggle;
  } state_t;

  // everything clear except the overflow and vblank flags
  localparam state_t STATE_RESET = {8'd0, 8'd0, STATUS_RESET, 8'd0, 8'd0, 8'd0, 8'd0,
                                    16'd0, 1'b0};

  typedef struct packed {
    logic [7:0]  read_data;
    logic        ok;
    logic [13:0] nametable_base;
    logic [5:0]  vram_increment;
    logic [12:0] sprite_pattern_base;
    logic [12:0] bg_pattern_base;
    logic [2:0]  control_flags;
    logic [7:0]  render_mask;
    logic [7:0]  oam_address;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
    logic [15:0] vram_address;
  } result_t;

endpackage

[design/video_unit_register_file.sv]
// Top level of the video unit register file.
// One beat per cycle: each accepted request (bus read, bus write or status flag
// event) updates the register state and loads its result into the output register
// at the accepting edge, so the result shows on the out_ ports from the next cycle.
// in_ready stays high while the output register is empty or being drained, so with
// out_ready held high the block takes a request every clock; throughput is set only
// by the single output register. Registers mirror every eight bytes of address;
// every result carries the decoded control fields and register contents as they
// stand after that beat.
module video_unit_register_file import vurf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [1:0]  in_flag_select,
  input  logic        in_flag_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_ok,
  output logic [13:0] out_nametable_base,
  output logic [5:0]  out_vram_increment,
  output logic [12:0] out_sprite_pattern_base,
  output logic [12:0] out_bg_pattern_base,
  output logic [2:0]  out_control_flags,
  output logic [7:0]  out_render_mask,
  output logic [7:0]  out_oam_address,
  output logic [7:0]  out_scroll_x,
  output logic [7:0]  out_scroll_y,
  output logic [15:0] out_vram_address
);

  state_t  state_r, state_nxt;
  result_t result_nxt, result_r;
  logic    out_valid_r;
  logic    accept;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  vurf_core u_core (
    .state       (state_r),
    .req_type    (in_req_type),
    .address     (in_address),
    .write_data  (in_write_data),
    .flag_select (in_flag_select),
    .flag_value  (in_flag_value),
    .state_nxt   (state_nxt),
    .result      (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result_r <= result_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_read_data           = result_r.read_data;
  assign out_ok                  = result_r.ok;
  assign out_nametable_base      = result_r.nametable_base;
  assign out_vram_increment      = result_r.vram_increment;
  assign out_sprite_pattern_base = result_r.sprite_pattern_base;
  assign out_bg_pattern_base     = result_r.bg_pattern_base;
  assign out_control_flags       = result_r.control_flags;
  assign out_render_mask         = result_r.render_mask;
  assign out_oam_address         = result_r.oam_address;
  assign out_scroll_x            = result_r.scroll_x;
  assign out_scroll_y            = result_r.scroll_y;
  assign out_vram_address        = result_r.vram_address;

endmodule

[design/vurf_core.sv]
// Next-state and result logic for one bus access or flag event.
module vurf_core import vurf_pkg::*; (
  input  state_t      state,
  input  logic [1:0]  req_type,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [1:0]  flag_select,
  input  logic        flag_value,
  output state_t      state_nxt,
  output result_t     result
);

  logic [SEL_W-1:0] sel;
  logic [7:0]       data;
  logic             ok;

  assign sel = address[SEL_W-1:0];

  always_comb begin
    state_nxt = state;
    data      = 8'd0;
    ok        = 1'b0;
    case (req_type)
      REQ_READ: begin
        case (sel)
          SEL_STATUS: begin
            data = {state.status, 5'd0};
            state_nxt.status = {1'b0, state.status[1:0]};
            state_nxt.toggle = 1'b0;
            ok = 1'b1;
          end
          SEL_OAM_DATA: begin
            data = state.spr_byte;
            ok   = 1'b1;
          end
          SEL_VRAM_DATA: ok = 1'b1;
          default: ok = 1'b0;
        endcase
      end
      REQ_WRITE: begin
        ok = 1'b1;
        case (sel)
          SEL_CONTROL:  state_nxt.control  = write_data;
          SEL_MASK:     state_nxt.mask     = write_data;
          SEL_STATUS:   ok = 1'b0;
          SEL_OAM_ADDR: state_nxt.spr_ptr  = write_data;
          SEL_OAM_DATA: begin
            state_nxt.spr_byte = write_data;
            state_nxt.spr_ptr  = state.spr_ptr + 8'd1;
          end
          SEL_SCROLL: begin
            if (state.toggle) state_nxt.scroll_y = write_data;
            else state_nxt.scroll_x = write_data;
            state_nxt.toggle = ~state.toggle;
          end
          SEL_VRAM_ADDR: begin
            if (state.toggle) state_nxt.vid_ptr[7:0] = write_data;
            else state_nxt.vid_ptr[15:8] = write_data;
            state_nxt.toggle = ~state.toggle;
          end
          default: ok = 1'b1;  // vram data writes are dropped
        endcase
      end
      REQ_EVENT: begin
        ok = 1'b1;
        case (flag_select)
          FLAG_OVERFLOW: state_nxt.status[0] = flag_value;
          FLAG_HIT:      state_nxt.status[1] = flag_value;
          FLAG_VBLANK:   state_nxt.status[2] = flag_value;
          default:       ok = 1'b0;
        endcase
      end
      default: ok = 1'b0;
    endcase
  end

  // decoded views reflect the state after this beat
  always_comb begin
    result.read_data           = data;
    result.ok                  = ok;
    result.nametable_base      = NT_BASE + (NT_STEP * {12'd0, state_nxt.control[1:0]});
    result.vram_increment      = state_nxt.control[2] ? INC_WIDE : INC_NARROW;
    result.sprite_pattern_base = state_nxt.control[3] ? PATTERN_HI : 13'd0;
    result.bg_pattern_base     = state_nxt.control[4] ? PATTERN_HI : 13'd0;
    result.control_flags       = state_nxt.control[7:5];
    result.render_mask         = state_nxt.mask;
    result.oam_address         = state_nxt.spr_ptr;
    result.scroll_x            = state_nxt.scroll_x;
    result.scroll_y            = state_nxt.scroll_y;
    result.vram_address        = state_nxt.vid_ptr;
  end

endmodule

[design/vurf_checker.sv]
// Port-level assertions for the video unit register file, bound to the top level.
module vurf_checker import vurf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic        out_ok,
  input logic [13:0] out_nametable_base,
  input logic [5:0]  out_vram_increment,
  input logic [15:0] out_vram_address
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_ok)
      && $stable(out_vram_address))
    else $error("result beat changed while stalled");

  // nonzero read data only comes from an accepted access
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 8'd0 |-> out_ok)
    else $error("read data on rejected access");

  a_incr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vram_increment == INC_NARROW || out_vram_increment == INC_WIDE)
    else $error("bad vram increment");

  a_nt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nametable_base[9:0] == 10'd0 && out_nametable_base[13:12] == 2'b10)
    else $error("bad nametable base");

  // output register empty means the input side is open
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind video_unit_register_file vurf_checker u_vurf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_read_data      (out_read_data),
  .out_ok             (out_ok),
  .out_nametable_base (out_nametable_base),
  .out_vram_increment (out_vram_increment),
  .out_vram_address   (out_vram_address)
);

[test/tb_top.sv]
// Self-checking testbench for the video unit register file: directed table, then random beats.
`timescale 1ns / 1ps

module tb_top;
  import vurf_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [1:0] FLAG_UNUSED = 2'd3;
  localparam int NUM_DIRECTED = 26;
  localparam int RANDOM_BEATS = 1450;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LINES = 100;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [1:0]  fsel;
    logic        fval;
    logic        typed;
    logic [7:0]  exp_data;
    logic        exp_ok;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [1:0]  in_flag_select = '0;
  logic        in_flag_value = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_ok;
  logic [13:0] out_nametable_base;
  logic [5:0]  out_vram_increment;
  logic [12:0] out_sprite_pattern_base;
  logic [12:0] out_bg_pattern_base;
  logic [2:0]  out_control_flags;
  logic [7:0]  out_render_mask;
  logic [7:0]  out_oam_address;
  logic [7:0]  out_scroll_x;
  logic [7:0]  out_scroll_y;
  logic [15:0] out_vram_address;

  // typed-in read data / ok for the current beat, carried alongside the payload
  logic        cur_typed = 1'b0;
  logic [7:0]  cur_exp_data = '0;
  logic        cur_exp_ok = 1'b0;

  state_t      regfile_shadow;
  result_t     expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold = 0;

  video_unit_register_file DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_req_type             (in_req_type),
    .in_address              (in_address),
    .in_write_data           (in_write_data),
    .in_flag_select          (in_flag_select),
    .in_flag_value           (in_flag_value),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_read_data           (out_read_data),
    .out_ok                  (out_ok),
    .out_nametable_base      (out_nametable_base),
    .out_vram_increment      (out_vram_increment),
    .out_sprite_pattern_base (out_sprite_pattern_base),
    .out_bg_pattern_base     (out_bg_pattern_base),
    .out_control_flags       (out_control_flags),
    .out_render_mask         (out_render_mask),
    .out_oam_address         (out_oam_address),
    .out_scroll_x            (out_scroll_x),
    .out_scroll_y            (out_scroll_y),
    .out_vram_address        (out_vram_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one beat to the shadow registers and returns the result it should produce.
  function automatic result_t predict_access(logic [1:0] req, logic [15:0] addr,
                                             logic [7:0] wd, logic [1:0] fs, logic fv);
    result_t r;
    sel_t    sel;
    r = '0;
    sel = sel_t'(addr[SEL_W-1:0]);
    case (req)
      REQ_READ: begin
        case (sel)
          SEL_STATUS: begin
            r.read_data = {regfile_shadow.status, 5'd0};
            regfile_shadow.status[FLAG_VBLANK] = 1'b0;
            regfile_shadow.toggle = 1'b0;
            r.ok = 1'b1;
          end
          SEL_OAM_DATA: begin
            r.read_data = regfile_shadow.spr_byte;
            r.ok = 1'b1;
          end
          SEL_VRAM_DATA: r.ok = 1'b1;
          default: ;
        endcase
      end
      REQ_WRITE: begin
        r.ok = 1'b1;
        case (sel)
          SEL_CONTROL:  regfile_shadow.control = wd;
          SEL_MASK:     regfile_shadow.mask = wd;
          SEL_STATUS:   r.ok = 1'b0;
          SEL_OAM_ADDR: regfile_shadow.spr_ptr = wd;
          SEL_OAM_DATA: begin
            regfile_shadow.spr_byte = wd;
            regfile_shadow.spr_ptr = regfile_shadow.spr_ptr + 8'd1;
          end
          SEL_SCROLL: begin
            if (regfile_shadow.toggle) regfile_shadow.scroll_y = wd;
            else regfile_shadow.scroll_x = wd;
            regfile_shadow.toggle = ~regfile_shadow.toggle;
          end
          SEL_VRAM_ADDR: begin
            if (regfile_shadow.toggle) regfile_shadow.vid_ptr[7:0] = wd;
            else regfile_shadow.vid_ptr[15:8] = wd;
            regfile_shadow.toggle = ~regfile_shadow.toggle;
          end
          default: ;
        endcase
      end
      REQ_EVENT: begin
        if (fs inside {FLAG_OVERFLOW, FLAG_HIT, FLAG_VBLANK}) begin
          regfile_shadow.status[fs] = fv;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.nametable_base      = NT_BASE + NT_STEP * regfile_shadow.control[1:0];
    r.vram_increment      = regfile_shadow.control[2] ? INC_WIDE : INC_NARROW;
    r.sprite_pattern_base = regfile_shadow.control[3] ? PATTERN_HI : 13'd0;
    r.bg_pattern_base     = regfile_shadow.control[4] ? PATTERN_HI : 13'd0;
    r.control_flags       = regfile_shadow.control[7:5];
    r.render_mask         = regfile_shadow.mask;
    r.oam_address         = regfile_shadow.spr_ptr;
    r.scroll_x            = regfile_shadow.scroll_x;
    r.scroll_y            = regfile_shadow.scroll_y;
    r.vram_address        = regfile_shadow.vid_ptr;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                results_seen, name, got, want));
  endtask

  // Predict on acceptance first, then check whatever leaves the block on this edge.
  always @(posedge clk) begin
    result_t pred;
    result_t want;
    if (rst_n && in_valid && in_ready) begin
      pred = predict_access(in_req_type, in_address, in_write_data, in_flag_select,
                            in_flag_value);
      if (cur_typed) begin
        pred.read_data = cur_exp_data;
        pred.ok = cur_exp_ok;
      end
      expected_results.push_back(pred);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = expected_results.pop_front();
        check_field("read_data", out_read_data, want.read_data);
        check_field("ok", out_ok, want.ok);
        check_field("nametable_base", out_nametable_base, want.nametable_base);
        check_field("vram_increment", out_vram_increment, want.vram_increment);
        check_field("sprite_pattern_base", out_sprite_pattern_base,
                    want.sprite_pattern_base);
        check_field("bg_pattern_base", out_bg_pattern_base, want.bg_pattern_base);
        check_field("control_flags", out_control_flags, want.control_flags);
        check_field("render_mask", out_render_mask, want.render_mask);
        check_field("oam_address", out_oam_address, want.oam_address);
        check_field("scroll_x", out_scroll_x, want.scroll_x);
        check_field("scroll_y", out_scroll_y, want.scroll_y);
        check_field("vram_address", out_vram_address, want.vram_address);
      end
      results_seen++;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 93) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // Result side backpressure; no new hold starts in a calm window at the start of each cycle_count period.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ((cycle_count % 1000) >= 150 && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      sink_hold <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic stim_row_t random_row(logic [1:0] req, logic [SEL_W-1:0] sel);
    stim_row_t row;
    row.req      = req;
    row.addr     = {13'($urandom_range(0, 8191)), sel};
    row.wdata    = 8'($urandom_range(0, 255));
    row.fsel     = 2'($urandom_range(0, 2));
    row.fval     = 1'($urandom_range(0, 1));
    row.typed    = 1'b0;
    row.exp_data = '0;
    row.exp_ok   = 1'b0;
    return row;
  endfunction

  // Holds valid through backpressure; valid stays up between back-to-back beats.
  task automatic send_beat(stim_row_t row);
    int unsigned gap;
    gap = ((beats_sent % 300) < 50) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= row.req;
    in_address     <= row.addr;
    in_write_data  <= row.wdata;
    in_flag_select <= row.fsel;
    in_flag_value  <= row.fval;
    cur_typed      <= row.typed;
    cur_exp_data   <= row.exp_data;
    cur_exp_ok     <= row.exp_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  initial begin
    stim_row_t         directed [NUM_DIRECTED];
    stim_row_t         row;
    logic [SEL_W-1:0]  pair_sel;
    int unsigned       roll;

    // req, addr, wdata, fsel, fval, typed, read_data, ok
    directed = '{
      '{REQ_READ,   16'h2002, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'hA0, 1'b1},
      '{REQ_READ,   16'h2002, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h20, 1'b1},
      '{REQ_READ,   16'h2000, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h2002, 8'hFF, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h0000, 8'hFF, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b1},
      '{REQ_WRITE,  16'h2001, 8'hFF, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b1},
      '{REQ_WRITE,  16'h2003, 8'hFF, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b1},
      '{REQ_WRITE,  16'h2004, 8'hA5, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_READ,   16'h2004, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'hA5, 1'b1},
      '{REQ_WRITE,  16'h2005, 8'h12, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h200D, 8'h34, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h2006, 8'h3F, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h2006, 8'h10, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h2005, 8'hFF, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_READ,   16'h2002, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h2006, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_WRITE,  16'hFFFF, 8'h5A, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b1},
      '{REQ_READ,   16'hFFFF, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b1},
      '{REQ_EVENT,  16'h2000, 8'h00, FLAG_VBLANK,   1'b1, 1'b1, 8'h00, 1'b1},
      '{REQ_EVENT,  16'h2000, 8'h00, FLAG_HIT,      1'b1, 1'b1, 8'h00, 1'b1},
      '{REQ_EVENT,  16'h2000, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b1},
      '{REQ_READ,   16'hFFFA, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b0, 8'h00, 1'b0},
      '{REQ_EVENT,  16'h2000, 8'h00, FLAG_UNUSED,   1'b1, 1'b1, 8'h00, 1'b0},
      '{REQ_UNUSED, 16'h2002, 8'hFF, FLAG_OVERFLOW, 1'b1, 1'b1, 8'h00, 1'b0},
      '{REQ_READ,   16'h2001, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b0},
      '{REQ_WRITE,  16'h2000, 8'h00, FLAG_OVERFLOW, 1'b0, 1'b1, 8'h00, 1'b1}
    };

    regfile_shadow = '0;
    regfile_shadow.status = STATUS_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) send_beat(directed[i]);

    while (beats_sent < NUM_DIRECTED + RANDOM_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        // status read clears the latch, then a matched X/Y or high/low pair
        pair_sel = $urandom_range(0, 1) ? SEL_SCROLL : SEL_VRAM_ADDR;
        send_beat(random_row(REQ_READ, SEL_STATUS));
        send_beat(random_row(REQ_WRITE, pair_sel));
        send_beat(random_row(REQ_WRITE, pair_sel));
      end else if (roll < 55) begin
        send_beat(random_row(REQ_WRITE, 3'($urandom_range(0, 7))));
      end else if (roll < 80) begin
        send_beat(random_row(REQ_READ, 3'($urandom_range(0, 7))));
      end else if (roll < 93) begin
        send_beat(random_row(REQ_EVENT, 3'($urandom_range(0, 7))));
      end else if (roll < 97) begin
        row = random_row(REQ_EVENT, 3'($urandom_range(0, 7)));
        row.fsel = FLAG_UNUSED;
        send_beat(row);
      end else begin
        send_beat(random_row(REQ_UNUSED, 3'($urandom_range(0, 7))));
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) report_mismatch("expected results never arrived");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
